// File: sv/vus_pkg.sv
// Shared types and constants of the utterance segmenter.
// Holds the result action codes, the command and status structs that join
// the controller and the datapath, and the ring size limit.
package vus_pkg;

  localparam int MAX_PRESPEECH_FRAMES = 32;
  localparam int RING_W = 6;
  localparam int SLOT_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int TDATA_W = 56;
  localparam int ACTION_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PRESPEECH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_SILENCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOP = 2'd2;

  localparam logic [ACTION_W-1:0] ACT_OPEN = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REPLAY = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_STORE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DISPLACED = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLOSE = 3'd5;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_OPEN = 3'd1;
  localparam logic [2:0] OP_REPLAY = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_STORE = 3'd4;
  localparam logic [2:0] OP_DISPLACED = 3'd5;
  localparam logic [2:0] OP_CLOSE = 3'd6;
  localparam logic [2:0] OP_EOS_CLEAR = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       last;
  } vus_cmd_t;

  typedef struct packed {
    logic in_utterance;
    logic previous_speech;
    logic out_free;
    logic replay_done;
    logic store_displaces;
    logic store_closes;
    logic silence_over_end;
  } vus_status_t;

endpackage

// File: sv/vus_ctrl.sv
// Controller state machine of the utterance segmenter.
// Takes input transactions and sequences the datapath operations; depends on vus_pkg.
module vus_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,  // bit 0: speech, bits 7..1: zero
  input  logic                 s_tuser,  // bit 0: kind
  input  vus_pkg::vus_status_t status,
  output vus_pkg::vus_cmd_t    cmd
);
  import vus_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_OPEN = 3'd2;
  localparam logic [2:0] ST_REPLAY = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;
  localparam logic [2:0] ST_DISPLACED = 3'd6;
  localparam logic [2:0] ST_CLOSE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       kind;
  logic       speech;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind <= s_tuser;
      speech <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    cmd.last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (kind) begin
          if (status.in_utterance) begin
            state_next = ST_CLOSE;
          end else begin
            cmd.op = OP_EOS_CLEAR;
            state_next = ST_IDLE;
          end
        end else if (speech) begin
          if (status.previous_speech) begin
            state_next = ST_WRITE;
          end else if (status.in_utterance) begin
            state_next = ST_REPLAY;
          end else begin
            state_next = ST_OPEN;
          end
        end else begin
          state_next = ST_STORE;
        end
      end
      ST_OPEN: begin
        if (status.out_free) begin
          cmd.op = OP_OPEN;
          state_next = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (status.out_free) begin
          cmd.op = OP_REPLAY;
          if (status.replay_done) begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.op = OP_WRITE;
          cmd.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_STORE: begin
        if (status.out_free) begin
          cmd.op = OP_STORE;
          cmd.last = !(status.store_displaces || status.store_closes);
          if (status.store_displaces) begin
            state_next = ST_DISPLACED;
          end else if (status.store_closes) begin
            state_next = ST_CLOSE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DISPLACED: begin
        if (status.out_free) begin
          cmd.op = OP_DISPLACED;
          cmd.last = !status.silence_over_end;
          state_next = status.silence_over_end ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.op = OP_CLOSE;
          cmd.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/vus_datapath.sv
// Datapath of the utterance segmenter: configuration registers, ring and
// utterance counters, saturating sample total and the output register.
// Depends on vus_pkg; driven by the commands of vus_ctrl.
module vus_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [vus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vus_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  vus_pkg::vus_cmd_t               cmd,
  output vus_pkg::vus_status_t            status,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [vus_pkg::TDATA_W-1:0]     m_tdata,
  output logic [vus_pkg::ACTION_W-1:0]    m_tuser,
  output logic                            m_tlast
);
  import vus_pkg::*;

  logic [RING_W-1:0] prespeech_frames;
  logic [11:0]       end_silence_frames;
  logic [12:0]       hop_samples;

  logic [SLOT_W-1:0] ring_write_slot;
  logic [11:0]       silent_frame_count;
  logic              in_utterance;
  logic              previous_speech;
  logic [15:0]       utterance_counter;
  logic [31:0]       sample_total;
  logic [SLOT_W-1:0] replay_index;
  logic [SLOT_W-1:0] displaced_slot;

  logic [RING_W-1:0] n;
  logic [SLOT_W-1:0] start;
  logic [RING_W-1:0] replay_sum;
  logic [SLOT_W-1:0] replay_slot;
  logic [RING_W-1:0] start_plus;
  logic [SLOT_W-1:0] ring_write_slot_next;
  logic [32:0]       total_sum;
  logic [31:0]       total_added;
  logic [11:0]       silent_count_next;
  logic              emit;

  always_comb begin
    if (prespeech_frames == '0) begin
      n = RING_W'(1);
    end else if (prespeech_frames > RING_W'(MAX_PRESPEECH_FRAMES)) begin
      n = RING_W'(MAX_PRESPEECH_FRAMES);
    end else begin
      n = prespeech_frames;
    end
    start = ({1'b0, ring_write_slot} < n) ? ring_write_slot : '0;
    replay_sum = {1'b0, start} + {1'b0, replay_index};
    replay_slot = (replay_sum >= n) ? SLOT_W'(replay_sum - n) : replay_sum[SLOT_W-1:0];
    start_plus = {1'b0, start} + RING_W'(1);
    ring_write_slot_next = (start_plus >= n) ? '0 : start_plus[SLOT_W-1:0];
    total_sum = {1'b0, sample_total} + {20'd0, hop_samples};
    total_added = total_sum[32] ? '1 : total_sum[31:0];
    silent_count_next = (silent_frame_count == '1) ? silent_frame_count
                                                   : silent_frame_count + 12'd1;
  end

  assign emit = (cmd.op != OP_NONE) && (cmd.op != OP_EOS_CLEAR);

  assign status.in_utterance = in_utterance;
  assign status.previous_speech = previous_speech;
  assign status.out_free = !m_tvalid || m_tready;
  assign status.replay_done = ({1'b0, replay_index} == n - RING_W'(1));
  assign status.store_displaces = in_utterance && (silent_count_next > {6'd0, n});
  assign status.store_closes = in_utterance && (silent_count_next > end_silence_frames);
  assign status.silence_over_end = silent_frame_count > end_silence_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      prespeech_frames <= RING_W'(10);
      end_silence_frames <= 12'd100;
      hop_samples <= 13'd160;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRESPEECH: prespeech_frames <= cfg_data[RING_W-1:0];
        REG_END_SILENCE: end_silence_frames <= cfg_data[11:0];
        REG_HOP: hop_samples <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_write_slot <= '0;
      silent_frame_count <= '0;
      in_utterance <= 1'b0;
      previous_speech <= 1'b0;
      utterance_counter <= '0;
      sample_total <= '0;
      replay_index <= '0;
    end else begin
      case (cmd.op)
        OP_OPEN: begin
          utterance_counter <= utterance_counter + 16'd1;
          sample_total <= '0;
        end
        OP_REPLAY: begin
          sample_total <= total_added;
          if (status.replay_done) begin
            replay_index <= '0;
            ring_write_slot <= '0;
            silent_frame_count <= '0;
            in_utterance <= 1'b1;
          end else begin
            replay_index <= replay_index + SLOT_W'(1);
          end
        end
        OP_WRITE: begin
          sample_total <= total_added;
          previous_speech <= 1'b1;
        end
        OP_STORE: begin
          ring_write_slot <= ring_write_slot_next;
          silent_frame_count <= silent_count_next;
          previous_speech <= 1'b0;
        end
        OP_DISPLACED: begin
          sample_total <= total_added;
        end
        OP_CLOSE, OP_EOS_CLEAR: begin
          in_utterance <= 1'b0;
          sample_total <= '0;
          previous_speech <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_STORE) begin
      displaced_slot <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tlast <= cmd.last;
      m_tdata[TDATA_W-1:53] <= '0;
      m_tdata[20:5] <= (cmd.op == OP_OPEN) ? utterance_counter + 16'd1 : utterance_counter;
      case (cmd.op)
        OP_OPEN: begin
          m_tuser <= ACT_OPEN;
          m_tdata[4:0] <= '0;
          m_tdata[52:21] <= '0;
        end
        OP_REPLAY: begin
          m_tuser <= ACT_REPLAY;
          m_tdata[4:0] <= replay_slot;
          m_tdata[52:21] <= total_added;
        end
        OP_WRITE: begin
          m_tuser <= ACT_WRITE;
          m_tdata[4:0] <= '0;
          m_tdata[52:21] <= total_added;
        end
        OP_STORE: begin
          m_tuser <= ACT_STORE;
          m_tdata[4:0] <= start;
          m_tdata[52:21] <= sample_total;
        end
        OP_DISPLACED: begin
          m_tuser <= ACT_DISPLACED;
          m_tdata[4:0] <= displaced_slot;
          m_tdata[52:21] <= total_added;
        end
        default: begin
          m_tuser <= ACT_CLOSE;
          m_tdata[4:0] <= '0;
          m_tdata[52:21] <= sample_total;
        end
      endcase
    end
  end

endmodule

// File: sv/vad_utterance_segmenter.sv
// Utterance segmenter top level: joins the controller and the datapath.
// An item is accepted in IDLE and decided in DECIDE, then loads one result per cycle
// into the output register while it is free (up to 34 results on a speech onset with a
// full ring); a new item is taken only in IDLE, after the last result. Synchronous reset
// restores the register defaults (10, 100, 160) and clears the FSM and counters.
// Depends on vus_pkg, vus_ctrl and vus_datapath.
module vad_utterance_segmenter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // bit 0: speech, bits 7..1: zero
  input  logic                            s_tuser,  // bit 0: kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // bits 4..0: slot, 20..5: utterance_number, 52..21: utterance_samples, 55..53: zero
  output logic [vus_pkg::TDATA_W-1:0]     m_tdata,
  output logic [vus_pkg::ACTION_W-1:0]    m_tuser,  // bits 2..0: action
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vus_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vus_pkg::*;

  vus_cmd_t    cmd;
  vus_status_t status;

  assign cfg_ready = 1'b1;

  vus_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  vus_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
